### src/complex_rpn_stack_alu_core_macros.svh
// ----------------------------------------------------------------------------
// complex_rpn_stack_alu_core_macros
// Assertion helpers for the complex rpn stack alu.
// ----------------------------------------------------------------------------
`ifndef COMPLEX_RPN_STACK_ALU_CORE_MACROS_SVH
`define COMPLEX_RPN_STACK_ALU_CORE_MACROS_SVH

// property that must hold on every clock edge outside reset
`define CRS_ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// implication whose consequent is checked in the next cycle
`define CRS_ASSERT_NEXT(label, cond, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (prop)) \
      else $error(msg);

`endif

### src/crsalu_pkg.sv
// ----------------------------------------------------------------------------
// crsalu_pkg
// Shared types and constants of the complex rpn stack alu.
// ----------------------------------------------------------------------------
package crsalu_pkg;

   localparam int unsigned DefStackDepth = 16;

   typedef enum logic [2:0] {
      ACT_PUSH = 3'd0,
      ACT_ADD  = 3'd1,
      ACT_SUB  = 3'd2,
      ACT_MUL  = 3'd3,
      ACT_DIV  = 3'd4
   } action_type;

   typedef enum logic [1:0] {
      ERR_OK    = 2'd0,
      ERR_FEW   = 2'd1,
      ERR_FULL  = 2'd2,
      ERR_DIVZ  = 2'd3
   } err_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_CALC,
      ST_WAIT,
      ST_WRITE,
      ST_SHOW,
      ST_OUT
   } state_type;

   // controller to datapath commands
   typedef struct packed {
      logic       push_wr;   // write pushed value at count
      logic       rd_ops;    // read the two top entries
      logic       start;     // start arithmetic
      logic       res_wr;    // write result at count-2
      logic       rd_top;    // read current top
      logic [2:0] action;
   } cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic done;
      logic div_zero;
   } status_type;

   // saturate a signed value held in 66 bits to 32 bits
   function automatic logic [31:0] sat66(input logic signed [65:0] v);
      logic [31:0] r;
      if (v > 66'sd2147483647)       r = 32'h7FFF_FFFF;
      else if (v < -66'sd2147483648) r = 32'h8000_0000;
      else                           r = v[31:0];
      return r;
   endfunction

endpackage

### src/crsalu_div.sv
// ----------------------------------------------------------------------------
// crsalu_div
// Restoring divider, one quotient bit per cycle, floor of 2^16*num/den.
// ----------------------------------------------------------------------------
module crsalu_div
   import crsalu_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic signed [65:0] num,   // exact numerator
   input  logic        [63:0] den,   // nonzero, at most 2^63
   output logic               done,
   output logic        [31:0] quo
);
   // 64-bit magnitude plus 16 fraction bits gives 80 steps, then one cycle
   // with done
   logic [6:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        neg_ff, neg_in;
   logic [64:0] rem_ff, rem_in;
   logic [79:0] q_ff, q_in;
   logic [79:0] sh_ff, sh_in;
   logic [63:0] den_ff, den_in;
   logic [63:0] mag;
   logic [65:0] trial;
   logic [80:0] fmag;
   logic [64:0] rem_sh;

   always_comb begin
      mag    = num[65] ? 64'(-num) : num[63:0];
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      neg_in  = neg_ff;
      rem_in  = rem_ff;
      q_in    = q_ff;
      sh_in   = sh_ff;
      den_in  = den_ff;
      rem_sh  = {rem_ff[63:0], sh_ff[79]};
      trial   = {1'b0, rem_sh} - {2'b0, den_ff};
      done    = 1'b0;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = 7'd80;
         neg_in  = num[65];
         rem_in  = '0;
         q_in    = '0;
         sh_in   = {mag, 16'h0};
         den_in  = den;
      end else if (busy_ff) begin
         if (cnt_ff == 7'd0) begin
            busy_in = 1'b0;
            done    = 1'b1;
         end else begin
            sh_in  = {sh_ff[78:0], 1'b0};
            cnt_in = cnt_ff - 7'd1;
            if (!trial[65]) begin
               rem_in = trial[64:0];
               q_in   = {q_ff[78:0], 1'b1};
            end else begin
               rem_in = rem_sh;
               q_in   = {q_ff[78:0], 1'b0};
            end
         end
      end
      fmag = {1'b0, q_ff} + {80'h0, (neg_ff && rem_ff != '0)};
      if (neg_ff) quo = (fmag > 81'h8000_0000) ? 32'h8000_0000 : 32'(-fmag[31:0]);
      else        quo = (fmag > 81'h7FFF_FFFF) ? 32'h7FFF_FFFF : fmag[31:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      neg_ff <= neg_in;
      rem_ff <= rem_in;
      q_ff   <= q_in;
      sh_ff  <= sh_in;
      den_ff <= den_in;
   end
endmodule

### src/crsalu_datapath.sv
// ----------------------------------------------------------------------------
// crsalu_datapath
// Stack memory, complex arithmetic and result register.
// ----------------------------------------------------------------------------
module crsalu_datapath
   import crsalu_pkg::*;
#(
   parameter int unsigned StackDepth = DefStackDepth,
   parameter int unsigned CntW = $clog2(StackDepth + 1),
   parameter int unsigned AdrW = $clog2(StackDepth)
)(
   input  logic              clock,
   input  logic              reset,
   input  cmd_type           cmd,
   input  logic [CntW-1:0]   count,
   input  logic [31:0]       push_real,
   input  logic [31:0]       push_imag,
   output status_type        status,
   output logic [31:0]       top_real,
   output logic [31:0]       top_imag
);
   logic [63:0] mem [StackDepth];
   logic [63:0] rd_ff;
   logic [63:0] l_ff, r_ff;
   logic        sel_ff;   // 0 reads right, 1 reads left
   logic [CntW-1:0] ra;
   logic [CntW-1:0] wa;
   logic [63:0]     wd;
   logic            we;
   logic signed [31:0] a, b, c, d;
   logic signed [63:0] p_ff [4];
   logic signed [63:0] q_ff [2];
   logic [2:0]  ph_ff, ph_in;
   logic        dstart;
   logic        done_c, dz_c;
   logic        d0, d1;
   logic [31:0] q0, q1;
   logic signed [65:0] nre, nim;
   logic [63:0] den;
   logic [31:0] res_re_ff, res_im_ff;
   logic        got0_ff, got1_ff;
   logic signed [65:0] fl_re, fl_im;

   assign a = l_ff[63:32];
   assign b = l_ff[31:0];
   assign c = r_ff[63:32];
   assign d = r_ff[31:0];

   assign status = {done_c, dz_c};

   always_comb begin
      ra = count - CntW'(1);
      if (cmd.rd_ops && sel_ff) ra = count - CntW'(2);
      we = cmd.push_wr || cmd.res_wr;
      wa = cmd.push_wr ? count : count - CntW'(2);
      wd = cmd.push_wr ? {push_real, push_imag} : {res_re_ff, res_im_ff};
   end

   always_ff @(posedge clock) begin
      if (we) mem[wa[AdrW-1:0]] <= wd;
      rd_ff <= mem[ra[AdrW-1:0]];
   end

   // operand capture: while rd_ops is held, right is read first, then left
   always_ff @(posedge clock) begin
      if (reset) sel_ff <= 1'b0;
      else if (cmd.rd_ops) sel_ff <= ~sel_ff;
      else sel_ff <= 1'b0;
      if (ph_ff == 3'd1) r_ff <= rd_ff;
      if (ph_ff == 3'd2) l_ff <= rd_ff;
      else if (cmd.rd_top) l_ff <= rd_ff;
   end

   // sequencing: 1 wait right, 2 wait left, 3 products, 4 sums, 5 finish
   always_comb begin
      ph_in  = ph_ff;
      dstart = 1'b0;
      done_c = 1'b0;
      if (cmd.start) ph_in = 3'd1;
      else begin
         unique case (ph_ff)
            3'd1: ph_in = 3'd2;
            3'd2: ph_in = 3'd3;
            3'd3: ph_in = 3'd4;
            3'd4: begin
               ph_in = 3'd5;
               if (cmd.action == ACT_DIV && !dz_c) dstart = 1'b1;
            end
            3'd5: begin
               if (cmd.action != ACT_DIV || dz_c ||
                   (got0_ff && got1_ff)) begin
                  ph_in  = 3'd0;
                  done_c = 1'b1;
               end
            end
            default: ph_in = ph_ff;
         endcase
      end
   end

   always_comb begin
      nre = 66'(p_ff[0]) + 66'(p_ff[1]);
      nim = 66'(p_ff[2]) - 66'(p_ff[3]);
      if (cmd.action == ACT_MUL) begin
         nre = 66'(p_ff[0]) - 66'(p_ff[1]);
         nim = 66'(p_ff[3]) + 66'(p_ff[2]);
      end
      den  = 64'(q_ff[0]) + 64'(q_ff[1]);
      dz_c = (den == 64'h0);
   end

   crsalu_div u_div_re (
      .clock(clock), .reset(reset), .start(dstart), .num(nre), .den(den),
      .done(d0), .quo(q0));
   crsalu_div u_div_im (
      .clock(clock), .reset(reset), .start(dstart), .num(nim), .den(den),
      .done(d1), .quo(q1));

   assign fl_re = nre >>> 16;
   assign fl_im = nim >>> 16;

   always_ff @(posedge clock) begin
      if (reset) begin
         ph_ff   <= '0;
         got0_ff <= 1'b0;
         got1_ff <= 1'b0;
      end else begin
         ph_ff <= ph_in;
         if (dstart || cmd.start) begin
            got0_ff <= 1'b0;
            got1_ff <= 1'b0;
         end else begin
            if (d0) got0_ff <= 1'b1;
            if (d1) got1_ff <= 1'b1;
         end
      end
      if (ph_ff == 3'd3) begin
         p_ff[0] <= a * c;
         p_ff[1] <= b * d;
         p_ff[2] <= b * c;
         p_ff[3] <= a * d;
         q_ff[0] <= c * c;
         q_ff[1] <= d * d;
      end
      if (ph_ff == 3'd4) begin
         unique case (cmd.action)
            ACT_ADD: begin
               res_re_ff <= sat66(66'(a) + 66'(c));
               res_im_ff <= sat66(66'(b) + 66'(d));
            end
            ACT_SUB: begin
               res_re_ff <= sat66(66'(a) - 66'(c));
               res_im_ff <= sat66(66'(b) - 66'(d));
            end
            ACT_MUL: begin
               res_re_ff <= sat66(fl_re);
               res_im_ff <= sat66(fl_im);
            end
            default: ;
         endcase
      end
      if (d0) res_re_ff <= q0;
      if (d1) res_im_ff <= q1;
   end

   assign top_real = l_ff[63:32];
   assign top_imag = l_ff[31:0];
endmodule

### src/crsalu_ctrl.sv
// ----------------------------------------------------------------------------
// crsalu_ctrl
// Request sequencer: checks, stack pointer and response handshake.
// ----------------------------------------------------------------------------
module crsalu_ctrl
   import crsalu_pkg::*;
#(
   parameter int unsigned StackDepth = DefStackDepth,
   parameter int unsigned CntW = $clog2(StackDepth + 1)
)(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_tvalid,
   output logic            req_tready,
   input  logic [2:0]      req_action,
   output logic            rsp_tvalid,
   input  logic            rsp_tready,
   input  status_type      status,
   output cmd_type         cmd,
   output logic [CntW-1:0] count,
   output logic            is_empty,
   output logic [1:0]      error_code,
   output logic            load_push
);
   state_type       state_ff, state_in;
   logic [CntW-1:0] cnt_ff, cnt_in;
   logic [2:0]      act_ff, act_in;
   err_type         err_ff, err_in;
   logic            rd2_ff, rd2_in;

   assign count      = cnt_ff;
   assign is_empty   = (cnt_ff == '0);
   assign error_code = err_ff;

   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      act_in     = act_ff;
      err_in     = err_ff;
      rd2_in     = 1'b0;
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      load_push  = 1'b0;
      cmd        = '0;
      cmd.action = act_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               act_in    = req_action;
               load_push = 1'b1;
               err_in    = ERR_OK;
               state_in  = ST_SHOW;
               if (req_action == ACT_PUSH) begin
                  if (cnt_ff >= CntW'(StackDepth)) err_in = ERR_FULL;
                  else state_in = ST_WRITE;
               end else if (req_action inside {ACT_ADD, ACT_SUB, ACT_MUL, ACT_DIV}) begin
                  if (cnt_ff < CntW'(2)) err_in = ERR_FEW;
                  else state_in = ST_READ;
               end
            end
         end
         ST_READ: begin
            cmd.rd_ops = 1'b1;
            cmd.start  = !rd2_ff;
            rd2_in     = 1'b1;
            if (rd2_ff) state_in = ST_CALC;
         end
         ST_CALC: begin
            if (status.done) begin
               if (act_ff == ACT_DIV && status.div_zero) begin
                  err_in   = ERR_DIVZ;
                  state_in = ST_SHOW;
               end else begin
                  state_in = ST_WRITE;
               end
            end
         end
         ST_WRITE: begin
            if (act_ff == ACT_PUSH) begin
               cmd.push_wr = 1'b1;
               cnt_in      = cnt_ff + CntW'(1);
            end else begin
               cmd.res_wr = 1'b1;
               cnt_in     = cnt_ff - CntW'(1);
            end
            state_in = ST_SHOW;
         end
         ST_SHOW: begin
            // read address settles on count-1, data registered next cycle
            state_in = ST_WAIT;
         end
         ST_WAIT: begin
            cmd.rd_top = 1'b1;
            state_in   = ST_OUT;
         end
         ST_OUT: begin
            rsp_tvalid = 1'b1;
            if (rsp_tready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
         rd2_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         rd2_ff   <= rd2_in;
      end
      act_ff <= act_in;
      err_ff <= err_in;
   end
endmodule

### src/complex_rpn_stack_alu_core.sv
// ----------------------------------------------------------------------------
// complex_rpn_stack_alu_core
// Reverse-Polish stack machine on Q16.16 complex numbers.
// One request at a time. A push is written straight to the stack, while add,
// subtract, multiply and divide first read both operands and compute; a request
// refused for too few entries, a full stack or an unknown action goes straight
// to the response. A divide waits for the two bit-serial dividers that produce
// 80 quotient bits each, and a divide by zero answers without them.
// Each request gets exactly one response with the new top and an error code.
// ----------------------------------------------------------------------------
`include "complex_rpn_stack_alu_core_macros.svh"

module complex_rpn_stack_alu_core
   import crsalu_pkg::*;
#(
   parameter int unsigned StackDepth = DefStackDepth
)(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [71:0] req_tdata,   // action[2:0], push_real[34:3], push_imag[66:35]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata    // top_real[31:0], top_imag[63:32], is_empty[64],
                                    // error_code[66:65]
);
   localparam int unsigned CntW = $clog2(StackDepth + 1);
   localparam int unsigned AdrW = (StackDepth > 1) ? $clog2(StackDepth) : 1;

   cmd_type         cmd;
   status_type      status;
   logic [CntW-1:0] count;
   logic            is_empty;
   logic [1:0]      error_code;
   logic            load_push;
   logic [31:0]     preal_ff, pimag_ff;
   logic [31:0]     top_real, top_imag;
   logic            full_rsp;

   always_ff @(posedge clock) begin
      if (load_push) begin
         preal_ff <= req_tdata[34:3];
         pimag_ff <= req_tdata[66:35];
      end
   end

   crsalu_ctrl #(.StackDepth(StackDepth), .CntW(CntW)) u_ctrl (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_action(req_tdata[2:0]),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .status(status), .cmd(cmd), .count(count),
      .is_empty(is_empty), .error_code(error_code), .load_push(load_push));

   crsalu_datapath #(.StackDepth(StackDepth), .CntW(CntW), .AdrW(AdrW)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .count(count),
      .push_real(preal_ff), .push_imag(pimag_ff), .status(status),
      .top_real(top_real), .top_imag(top_imag));

   assign rsp_tdata = {5'h0, error_code, is_empty,
                       is_empty ? 32'h0 : top_imag, is_empty ? 32'h0 : top_real};

   assign full_rsp = rsp_tvalid && (error_code == ERR_FULL);

   `CRS_ASSERT_CLK(a_no_overlap, !(req_tready && rsp_tvalid), "request during response")
   `CRS_ASSERT_CLK(a_count_range, count <= CntW'(StackDepth), "stack count beyond depth")
   `CRS_ASSERT_NEXT(a_full_keeps, full_rsp, count == $past(count), "full push moved count")
endmodule
